// ----- rtl/core/oale_pkg.sv -----
`timescale 1ns / 1ps

package oale_pkg;

    // Default list capacity
    localparam int DEPTH_DEF = 32;

    // Fixed field widths
    localparam int KIND_W    = 3;
    localparam int POS_W     = 6;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 6;

    // Stream beat widths (fields plus zero fill to whole bytes)
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_POP    = 3'd2,
        KIND_DELETE = 3'd3,
        KIND_SEARCH = 3'd4,
        KIND_MODIFY = 3'd5,
        KIND_CLEAR  = 3'd6
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // What the datapath does with an accepted request
    typedef enum logic [1:0] {
        MODE_SINGLE,    // no memory walk
        MODE_UP,        // shift tail up, then write the new word
        MODE_DOWN,      // shift tail down over the removed slot
        MODE_SEARCH     // scan from slot 1 for a match
    } mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_MOVE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;     // latch the request beat
        logic start;    // register the plan, arm walk pointers
        logic step;     // issue one memory read and advance
        logic finish;   // final write, count update, load result
    } cmd_t;

    typedef struct packed {
        mode_t plan_mode;
        logic  rem_zero;
        logic  hit;
        logic  out_busy;
    } stat_t;

endpackage

// ----- rtl/core/oale_ctrl.sv -----
`timescale 1ns / 1ps

module oale_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  oale_pkg::stat_t stat,
    output oale_pkg::cmd_t  cmd
);

    oale_pkg::state_t state_reg;
    oale_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oale_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            oale_pkg::S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    state_next = oale_pkg::S_CHECK;
                end
            end
            oale_pkg::S_CHECK:
            begin
                if (stat.plan_mode == oale_pkg::MODE_SINGLE)
                begin
                    state_next = oale_pkg::S_FINISH;
                end
                else
                begin
                    state_next = oale_pkg::S_MOVE;
                end
            end
            oale_pkg::S_MOVE:
            begin
                // last pending write or compare lands on this edge
                if (stat.rem_zero || stat.hit)
                begin
                    state_next = oale_pkg::S_FINISH;
                end
            end
            oale_pkg::S_FINISH:
            begin
                // wait here while the previous result beat is still held
                if (!stat.out_busy)
                begin
                    state_next = oale_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = oale_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            oale_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            oale_pkg::S_CHECK:
            begin
                cmd.start = 1'b1;
            end
            oale_pkg::S_MOVE:
            begin
                cmd.step = !stat.rem_zero && !stat.hit;
            end
            oale_pkg::S_FINISH:
            begin
                cmd.finish = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/oale_dpath.sv -----
`timescale 1ns / 1ps

module oale_dpath #(
    parameter int DEPTH = oale_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  oale_pkg::cmd_t                    cmd,
    output oale_pkg::stat_t                   stat,
    input  logic [oale_pkg::KIND_W-1:0]       req_kind,
    input  logic [oale_pkg::POS_W-1:0]        req_position,
    input  logic signed [oale_pkg::VAL_W-1:0] req_value,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [oale_pkg::STAT_W-1:0]       res_status,
    output logic                              res_found,
    output logic [oale_pkg::CNT_OUT_W-1:0]    res_found_position,
    output logic [oale_pkg::CNT_OUT_W-1:0]    res_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > oale_pkg::POS_W) ? CW : oale_pkg::POS_W) + 1;

    logic [oale_pkg::VAL_W-1:0] mem [DEPTH];

    // request
    logic [oale_pkg::KIND_W-1:0]   kind_reg;
    logic [oale_pkg::POS_W-1:0]    pos_reg;
    logic [oale_pkg::VAL_W-1:0]    value_reg;

    // plan
    oale_pkg::mode_t               mode_reg;
    oale_pkg::status_t             status_reg;
    logic [AW-1:0]                 idx_reg;
    logic                          mod_reg;
    logic                          clr_reg;

    // walk
    logic [AW-1:0]                 src_reg;
    logic [AW-1:0]                 dst_reg;
    logic [CW-1:0]                 rem_reg;
    logic                          rd_pend_reg;
    logic [oale_pkg::VAL_W-1:0]    rdata_reg;
    logic                          found_reg;
    logic [CW-1:0]                 fpos_reg;

    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;

    // result
    logic                          out_valid_reg;
    logic [oale_pkg::STAT_W-1:0]   out_status_reg;
    logic                          out_found_reg;
    logic [oale_pkg::CNT_OUT_W-1:0] out_fpos_reg;
    logic [oale_pkg::CNT_OUT_W-1:0] out_count_reg;

    // plan logic
    logic [XW-1:0]                 pos_x;
    logic [XW-1:0]                 cnt_x;
    logic                          is_full;
    logic                          no_entries;
    logic                          ins_bad;
    logic                          slot_bad;
    oale_pkg::mode_t               plan_mode;
    oale_pkg::status_t             plan_status;
    logic [XW-1:0]                 plan_ix;
    logic                          plan_mod;
    logic                          plan_clr;
    logic [CW-1:0]                 init_rem;
    logic [AW-1:0]                 init_src;

    logic                          hit;
    logic                          shift_wr;
    logic                          fin_wr;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [oale_pkg::VAL_W-1:0]    wr_data;

    assign pos_x      = XW'(pos_reg);
    assign cnt_x      = XW'(count_reg);
    assign is_full    = (cnt_x == XW'(DEPTH));
    assign no_entries = (count_reg == '0);
    assign ins_bad    = (pos_x == '0) || (pos_x > (cnt_x + XW'(1)));
    assign slot_bad   = (pos_x == '0) || (pos_x > cnt_x);

    always_comb
    begin
        plan_mode   = oale_pkg::MODE_SINGLE;
        plan_status = oale_pkg::ST_OK;
        plan_ix     = '0;
        plan_mod    = 1'b0;
        plan_clr    = 1'b0;
        unique case (oale_pkg::kind_t'(kind_reg))
            oale_pkg::KIND_PUSH:
            begin
                if (is_full)
                    plan_status = oale_pkg::ST_FULL;
                else
                    plan_mode = oale_pkg::MODE_UP;
            end
            oale_pkg::KIND_INSERT:
            begin
                priority if (is_full)
                    plan_status = oale_pkg::ST_FULL;
                else if (ins_bad)
                    plan_status = oale_pkg::ST_RANGE;
                else
                begin
                    plan_mode = oale_pkg::MODE_UP;
                    plan_ix   = pos_x - XW'(1);
                end
            end
            oale_pkg::KIND_POP:
            begin
                if (no_entries)
                    plan_status = oale_pkg::ST_EMPTY;
                else
                    plan_mode = oale_pkg::MODE_DOWN;
            end
            oale_pkg::KIND_DELETE:
            begin
                priority if (no_entries)
                    plan_status = oale_pkg::ST_EMPTY;
                else if (slot_bad)
                    plan_status = oale_pkg::ST_RANGE;
                else
                begin
                    plan_mode = oale_pkg::MODE_DOWN;
                    plan_ix   = pos_x - XW'(1);
                end
            end
            oale_pkg::KIND_SEARCH:
            begin
                if (no_entries)
                    plan_status = oale_pkg::ST_EMPTY;
                else
                    plan_mode = oale_pkg::MODE_SEARCH;
            end
            oale_pkg::KIND_MODIFY:
            begin
                priority if (no_entries)
                    plan_status = oale_pkg::ST_EMPTY;
                else if (slot_bad)
                    plan_status = oale_pkg::ST_RANGE;
                else
                begin
                    plan_mod = 1'b1;
                    plan_ix  = pos_x - XW'(1);
                end
            end
            oale_pkg::KIND_CLEAR:
            begin
                plan_clr = 1'b1;
            end
            default:
            begin
                plan_mode = oale_pkg::MODE_SINGLE;
            end
        endcase
    end

    // walk length and first source slot
    always_comb
    begin
        unique case (plan_mode)
            oale_pkg::MODE_UP:
            begin
                init_rem = CW'(cnt_x - plan_ix);
                init_src = AW'(cnt_x - XW'(1));
            end
            oale_pkg::MODE_DOWN:
            begin
                init_rem = CW'(cnt_x - plan_ix - XW'(1));
                init_src = AW'(plan_ix + XW'(1));
            end
            oale_pkg::MODE_SEARCH:
            begin
                init_rem = count_reg;
                init_src = '0;
            end
            default:
            begin
                init_rem = '0;
                init_src = '0;
            end
        endcase
    end

    assign hit = rd_pend_reg && !found_reg && (mode_reg == oale_pkg::MODE_SEARCH)
                 && (rdata_reg == value_reg);

    // single write port: shift moves during the walk, final word at finish
    assign shift_wr = rd_pend_reg && ((mode_reg == oale_pkg::MODE_UP) ||
                                      (mode_reg == oale_pkg::MODE_DOWN));
    assign fin_wr   = cmd.finish && ((mode_reg == oale_pkg::MODE_UP) || mod_reg);
    assign wr_en    = shift_wr || fin_wr;
    assign wr_addr  = shift_wr ? dst_reg : idx_reg;
    assign wr_data  = shift_wr ? rdata_reg : value_reg;

    always_comb
    begin
        unique case (mode_reg)
            oale_pkg::MODE_UP:     count_next = count_reg + CW'(1);
            oale_pkg::MODE_DOWN:   count_next = count_reg - CW'(1);
            oale_pkg::MODE_SINGLE: count_next = clr_reg ? '0 : count_reg;
            default:               count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.step)
        begin
            rdata_reg <= mem[src_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.step;
            if (cmd.finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= req_kind;
            pos_reg   <= req_position;
            value_reg <= req_value;
        end
        if (cmd.start)
        begin
            mode_reg   <= plan_mode;
            status_reg <= plan_status;
            idx_reg    <= AW'(plan_ix);
            mod_reg    <= plan_mod;
            clr_reg    <= plan_clr;
            src_reg    <= init_src;
            rem_reg    <= init_rem;
            found_reg  <= 1'b0;
            fpos_reg   <= '0;
        end
        if (cmd.step)
        begin
            rem_reg <= rem_reg - CW'(1);
            unique case (mode_reg)
                oale_pkg::MODE_UP:
                begin
                    dst_reg <= src_reg + AW'(1);
                    src_reg <= src_reg - AW'(1);
                end
                oale_pkg::MODE_DOWN:
                begin
                    dst_reg <= src_reg - AW'(1);
                    src_reg <= src_reg + AW'(1);
                end
                default:
                begin
                    dst_reg <= src_reg;
                    src_reg <= src_reg + AW'(1);
                end
            endcase
        end
        if (hit)
        begin
            found_reg <= 1'b1;
            fpos_reg  <= CW'(dst_reg) + CW'(1);
        end
        if (cmd.finish)
        begin
            out_status_reg <= status_reg;
            out_found_reg  <= found_reg;
            out_fpos_reg   <= oale_pkg::CNT_OUT_W'(fpos_reg);
            out_count_reg  <= oale_pkg::CNT_OUT_W'(count_next);
        end
    end

    assign stat.plan_mode = plan_mode;
    assign stat.rem_zero  = (rem_reg == '0);
    assign stat.hit       = hit;
    assign stat.out_busy  = out_valid_reg && !res_ready;

    assign res_valid          = out_valid_reg;
    assign res_status         = out_status_reg;
    assign res_found          = out_found_reg;
    assign res_found_position = out_fpos_reg;
    assign res_entry_count    = out_count_reg;

endmodule

// ----- rtl/core/ordered_array_list_engine.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Beat fields (low bit up)
// -------  ---  -----------------------------------------------------------
// s_*      in   tuser: kind[2:0]; tdata: position[5:0], value[37:6], zero fill
// m_*      out  tdata: status[1:0], found[2], found_position[8:3],
//                      entry_count[14:9], zero fill
//
// One request at a time. After accept, a check state registers the plan; a
// request with a memory walk then moves (push/insert/pop/delete) or reads
// (search, up to the first match) the entries in a move state, and a finish
// state loads the result; one without a walk (modify, clear, rejects) goes
// from check straight to finish. The walk is paced by the single read port of
// the entry memory, one entry per cycle, reads and shifted writes overlapped.
// Reset clears the count and the control state only; the entry memory is not
// cleared. A waiting result stalls only the finish step of the next request.

module ordered_array_list_engine #(
    parameter int DEPTH = oale_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [oale_pkg::S_TDATA_W-1:0]   s_tdata,   // position, value
    input  logic [oale_pkg::KIND_W-1:0]      s_tuser,   // kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [oale_pkg::M_TDATA_W-1:0]   m_tdata    // status, found,
                                                        // found_position, entry_count
);

    oale_pkg::cmd_t  cmd;
    oale_pkg::stat_t stat;

    logic [oale_pkg::POS_W-1:0]        req_position;
    logic signed [oale_pkg::VAL_W-1:0] req_value;

    logic [oale_pkg::STAT_W-1:0]       res_status;
    logic                              res_found;
    logic [oale_pkg::CNT_OUT_W-1:0]    res_found_position;
    logic [oale_pkg::CNT_OUT_W-1:0]    res_entry_count;

    // unpack request beat
    assign req_position = s_tdata[oale_pkg::POS_W-1:0];
    assign req_value    = s_tdata[oale_pkg::POS_W +: oale_pkg::VAL_W];

    oale_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    oale_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .req_kind           (s_tuser),
        .req_position       (req_position),
        .req_value          (req_value),
        .res_valid          (m_tvalid),
        .res_ready          (m_tready),
        .res_status         (res_status),
        .res_found          (res_found),
        .res_found_position (res_found_position),
        .res_entry_count    (res_entry_count)
    );

    // pack result beat, one zero bit of fill on top
    assign m_tdata = {1'b0, res_entry_count, res_found_position, res_found, res_status};

endmodule

// ----- verif/ordered_array_list_engine_tb.sv -----
`timescale 1ns / 1ps

module ordered_array_list_engine_tb;

    localparam int LIST_DEPTH   = oale_pkg::DEPTH_DEF;
    localparam int KIND_W       = oale_pkg::KIND_W;
    localparam int POS_W        = oale_pkg::POS_W;
    localparam int VAL_W        = oale_pkg::VAL_W;
    localparam int CNT_OUT_W    = oale_pkg::CNT_OUT_W;
    localparam int S_TDATA_W    = oale_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = oale_pkg::M_TDATA_W;
    localparam int RANDOM_ITEMS = 1950;
    localparam int QUIET_TAIL   = 300;          // last stretch runs with no idling
    localparam int CYCLE_LIMIT  = 600000;       // watchdog bound on the whole run
    localparam int DRAIN_CYCLES = LIST_DEPTH + 8;

    // Kind code the block must ignore (beyond the package enum)
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    // Words that make matches and sign edges likely
    localparam logic [VAL_W-1:0] WORD_POOL [8] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_0064, 32'hFFFF_FF9C
    };

    // Per-mode kind weights, in kind code order 0..7 (sum 100)
    localparam int KIND_WEIGHT [3][8] = '{
        '{30, 35,  5,  5, 12, 10, 1, 2},        // grow toward full
        '{ 5,  5, 30, 30, 15, 12, 1, 2},        // drain toward empty
        '{15, 18, 14, 16, 18, 15, 2, 2}         // hover
    };

    typedef enum int {GROW, SHRINK, HOVER} drift_t;

    // One expected result beat
    typedef struct packed {
        oale_pkg::status_t      status;
        logic                   found;
        logic [POS_W-1:0]       found_pos;
        logic [CNT_OUT_W-1:0]   count;
    } reply_t;

    // Shadow list plus the queue of replies still owed by the block
    class list_scoreboard;
        logic [VAL_W-1:0] words [LIST_DEPTH];
        int unsigned      count  = 0;
        int unsigned      errors = 0;
        reply_t           pending [$];

        // Shift the tail up one slot and place the word at idx (0-based)
        function void open_slot(int unsigned idx, logic [VAL_W-1:0] word);
            for (int unsigned i = count; i > idx; i--)
                words[i] = words[i - 1];
            words[idx] = word;
            count++;
        endfunction

        // Drop slot idx (0-based), pulling the tail down
        function void close_slot(int unsigned idx);
            for (int unsigned i = idx; i + 1 < count; i++)
                words[i] = words[i + 1];
            count--;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                   logic [VAL_W-1:0] word);
            reply_t r;
            r = '{status: oale_pkg::ST_OK, found: 1'b0, found_pos: '0, count: '0};
            case (kind)
                oale_pkg::KIND_PUSH:
                    if (count >= LIST_DEPTH) r.status = oale_pkg::ST_FULL;
                    else open_slot(0, word);
                oale_pkg::KIND_INSERT:
                    // fullness wins over a bad position
                    if (count >= LIST_DEPTH) r.status = oale_pkg::ST_FULL;
                    else if (pos < 1 || pos > count + 1) r.status = oale_pkg::ST_RANGE;
                    else open_slot(pos - 1, word);
                oale_pkg::KIND_POP:
                    if (count == 0) r.status = oale_pkg::ST_EMPTY;
                    else close_slot(0);
                oale_pkg::KIND_DELETE:
                    if (count == 0) r.status = oale_pkg::ST_EMPTY;
                    else if (pos < 1 || pos > count) r.status = oale_pkg::ST_RANGE;
                    else close_slot(pos - 1);
                oale_pkg::KIND_SEARCH:
                    if (count == 0) r.status = oale_pkg::ST_EMPTY;
                    else
                    begin
                        // last valid entry is part of the scan
                        for (int unsigned i = 0; i < count; i++)
                        begin
                            if (words[i] == word)
                            begin
                                r.found     = 1'b1;
                                r.found_pos = POS_W'(i + 1);
                                break;
                            end
                        end
                    end
                oale_pkg::KIND_MODIFY:
                    if (count == 0) r.status = oale_pkg::ST_EMPTY;
                    else if (pos < 1 || pos > count) r.status = oale_pkg::ST_RANGE;
                    else words[pos - 1] = word;
                oale_pkg::KIND_CLEAR:
                    count = 0;
                default: ;                      // unused kind: no change, status ok
            endcase
            r.count = CNT_OUT_W'(count);
            pending.push_back(r);
        endfunction

        function void check_reply(logic [M_TDATA_W-1:0] beat);
            reply_t want;
            if (pending.size() == 0)
            begin
                $error("result beat %h with no request outstanding", beat);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (beat[1:0] !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, beat[1:0]);
                errors++;
            end
            if (beat[2] !== want.found)
            begin
                $error("found: expected %0d, actual %0d", want.found, beat[2]);
                errors++;
            end
            if (beat[8:3] !== want.found_pos)
            begin
                $error("found_position: expected %0d, actual %0d", want.found_pos, beat[8:3]);
                errors++;
            end
            if (beat[14:9] !== want.count)
            begin
                $error("entry_count: expected %0d, actual %0d", want.count, beat[14:9]);
                errors++;
            end
        endfunction
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;      // position, value, zero fill
    logic [KIND_W-1:0]      s_tuser  = '0;      // kind
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;            // status, found, found_position,
                                                // entry_count, zero fill

    int unsigned    cycle_count   = 0;
    bit             src_idle_on   = 1'b0;       // random gaps on the request side
    bit             sink_stall_on = 1'b0;       // random back-pressure on results

    list_scoreboard sb = new;

    ordered_array_list_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Request beats are recorded at the edge that accepts them
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_request(s_tuser, s_tdata[POS_W-1:0], s_tdata[POS_W+VAL_W-1:POS_W]);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_reply(m_tdata);
    end

    // Result side: ready high, with stall bursts of random length while enabled
    always
    begin
        @(posedge clk);
        if (sink_stall_on && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        m_tready <= 1'b1;
    end

    // Drive one request beat and hold it until accepted. tvalid stays high
    // into the next call unless an idle burst is taken first.
    task automatic send_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                logic [VAL_W-1:0] word);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({word, pos});
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic logic [KIND_W-1:0] pick_kind(drift_t drift);
        int r;
        int acc;
        r   = $urandom_range(0, 99);
        acc = 0;
        for (int k = 0; k < 8; k++)
        begin
            acc += KIND_WEIGHT[drift][k];
            if (r < acc) return KIND_W'(k);
        end
        return oale_pkg::KIND_SEARCH;
    endfunction

    // Mostly legal slots, then edges just outside, then anything in the field
    function automatic logic [POS_W-1:0] pick_pos(logic [KIND_W-1:0] kind, int unsigned cnt);
        int unsigned hi;
        int unsigned r;
        hi = (kind == oale_pkg::KIND_INSERT) ? cnt + 1 : cnt;
        r  = $urandom_range(0, 99);
        if (kind == oale_pkg::KIND_INSERT || kind == oale_pkg::KIND_DELETE ||
            kind == oale_pkg::KIND_MODIFY)
        begin
            if (r < 80 && hi > 0) return POS_W'($urandom_range(1, hi));
            if (r < 90) return ($urandom_range(0, 1) != 0) ? POS_W'(0) : POS_W'(hi + 1);
            if (r < 96) return POS_W'($urandom_range(0, 33));
        end
        return POS_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [VAL_W-1:0] pick_word();
        if ($urandom_range(0, 9) < 3)
            return WORD_POOL[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Half the searches target a word that is in the list. The shadow count
    // may trail the block by one beat here; it only steers the choice.
    function automatic logic [VAL_W-1:0] pick_search_word();
        if (sb.count > 0 && $urandom_range(0, 1) != 0)
            return sb.words[$urandom_range(0, sb.count - 1)];
        return pick_word();
    endfunction

    initial
    begin
        int unsigned       sent;
        int unsigned       run_len;
        bit                quiet;
        drift_t            drift;
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  word;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list errors, position edges, sign extremes,
        // first match on duplicates, match in the last slot, ignored kind
        send_request(oale_pkg::KIND_SEARCH, 6'd0, 32'h0);
        send_request(oale_pkg::KIND_POP,    6'd0, 32'h0);
        send_request(oale_pkg::KIND_DELETE, 6'd1, 32'h0);
        send_request(oale_pkg::KIND_MODIFY, 6'd1, 32'h0);
        send_request(oale_pkg::KIND_INSERT, 6'd0, 32'h1);
        send_request(oale_pkg::KIND_INSERT, 6'd2, 32'h1);
        send_request(oale_pkg::KIND_INSERT, 6'd1, 32'h8000_0000);
        send_request(oale_pkg::KIND_PUSH,   6'd0, 32'h7FFF_FFFF);
        send_request(oale_pkg::KIND_PUSH,   6'd0, 32'hFFFF_FFFF);
        send_request(oale_pkg::KIND_INSERT, 6'd4, 32'h0);          // append at count+1
        send_request(oale_pkg::KIND_SEARCH, 6'd0, 32'h8000_0000);
        send_request(oale_pkg::KIND_SEARCH, 6'd0, 32'h0);          // hit in the last slot
        send_request(oale_pkg::KIND_SEARCH, 6'd0, 32'h5);
        send_request(oale_pkg::KIND_MODIFY, 6'd4, 32'hFFFF_FFFF);
        send_request(oale_pkg::KIND_SEARCH, 6'd0, 32'hFFFF_FFFF);  // duplicate: first wins
        send_request(oale_pkg::KIND_MODIFY, 6'd5, 32'h0);
        send_request(oale_pkg::KIND_MODIFY, 6'd0, 32'h0);
        send_request(oale_pkg::KIND_DELETE, 6'd0, 32'h0);
        send_request(oale_pkg::KIND_DELETE, 6'd5, 32'h0);
        send_request(oale_pkg::KIND_DELETE, 6'd4, 32'h0);
        send_request(oale_pkg::KIND_DELETE, 6'd2, 32'h0);
        send_request(oale_pkg::KIND_INSERT, 6'd63, 32'h1234_5678);
        send_request(KIND_UNUSED,           6'd63, 32'hFFFF_FFFF);
        send_request(oale_pkg::KIND_CLEAR,  6'd0, 32'h0);
        send_request(oale_pkg::KIND_SEARCH, 6'd0, 32'hFFFF_FFFF);

        // Random: runs that drift the fill level up, down or keep it level,
        // so full and empty are both hit repeatedly
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drift   = drift_t'($urandom_range(0, 2));
            run_len = (drift == GROW) ? $urandom_range(50, 100) : $urandom_range(30, 80);
            quiet   = (sent + QUIET_TAIL >= RANDOM_ITEMS);
            src_idle_on   = !quiet && $urandom_range(0, 3) != 0;
            sink_stall_on = !quiet && $urandom_range(0, 3) != 0;
            repeat (run_len)
            begin
                kind = pick_kind(drift);
                word = (kind == oale_pkg::KIND_SEARCH) ? pick_search_word() : pick_word();
                send_request(kind, pick_pos(kind, sb.count), word);
                if (kind != KIND_UNUSED)
                    sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
